@@ hw/rtl/ckbm_pkg.sv @@
// shared types and constants for the coordinate keyed block map
package ckbm_pkg;

  // operation codes carried by an item
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // slot index width that covers the largest supported table
  localparam int unsigned SLOT_W = 12;
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned KIND_W = 16;

  // cells per ripple group along the chain
  localparam int unsigned GROUP = 8;

  // reply handed from cell to cell and through the reduction
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  last_key;
    logic [KIND_W-1:0] last_kind;
  } reply_t;

  // write port broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
  } cell_wr_t;

endpackage

@@ hw/rtl/ckbm_cell.sv @@
// one table entry: storage, key compare and chained reply
module ckbm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic                        clk_i,
  input  logic [ckbm_pkg::KEY_W-1:0]  key_i,
  input  logic [CW-1:0]               count_i,
  input  ckbm_pkg::cell_wr_t          wr_i,
  input  ckbm_pkg::reply_t            chain_i,
  output ckbm_pkg::reply_t            chain_o
);
  import ckbm_pkg::*;

  localparam logic [CW-1:0]     IdxC  = CW'(IDX);
  localparam logic [CW-1:0]     IdxP1 = CW'(IDX + 1);
  localparam logic [SLOT_W-1:0] IdxS  = SLOT_W'(IDX);

  logic [KEY_W-1:0]  key_q;
  logic [KIND_W-1:0] kind_q;
  logic              in_use;
  logic              is_last;
  reply_t            reply_d;
  reply_t            reply_q;

  // entry storage, written only when addressed
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.idx == IdxS)) begin
      key_q  <= wr_i.key;
      kind_q <= wr_i.kind;
    end
  end

  assign in_use  = (IdxC < count_i);
  assign is_last = (IdxP1 == count_i);

  // local reply: match info and the last entry for a swap delete
  always_comb begin
    reply_d           = '0;
    reply_d.hit       = in_use && (key_q == key_i);
    reply_d.slot      = reply_d.hit ? IdxS : '0;
    reply_d.kind      = reply_d.hit ? kind_q : '0;
    reply_d.last_key  = is_last ? key_q : '0;
    reply_d.last_kind = is_last ? kind_q : '0;
  end

  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
  end

  // merge with the neighbor's reply and pass it on
  assign chain_o = reply_t'(chain_i | reply_q);

endmodule

@@ hw/rtl/ckbm_reduce.sv @@
// two registered stages that merge the group replies of the cell chain
module ckbm_reduce #(
  parameter int unsigned NG = 32
) (
  input  logic             clk_i,
  input  ckbm_pkg::reply_t grp_i [NG],
  output ckbm_pkg::reply_t sum_o
);
  import ckbm_pkg::*;

  reply_t grp_q [NG];
  reply_t sum_d;
  reply_t sum_q;

  // capture every group output
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NG; k++) begin
      grp_q[k] <= grp_i[k];
    end
  end

  // at most one group carries a hit and one carries the last entry
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NG; k++) begin
      sum_d = reply_t'(sum_d | grp_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

@@ hw/rtl/coordinate_keyed_block_map_core.sv @@
// coordinate keyed block map: chain of entry cells with a packed table
// no new item is taken while busy; busy covers key compare in the cells,
//   two register stages that merge the chain replies, and the write-back
// reset clears the entry count and control; entry storage is not cleared
// results are strobed on done_o for one cycle and the receiver cannot stall
module coordinate_keyed_block_map_core #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [15:0] block_kind_i,
  output logic        done_o,
  output logic        found_o,
  output logic [7:0]  slot_o,
  output logic [15:0] kind_read_o,
  output logic [8:0]  entry_count_o,
  output logic        table_full_o
);
  import ckbm_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NG = (CAPACITY + GROUP - 1) / GROUP;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED1,
    ST_RED2,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_d;
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [KIND_W-1:0] bkind_q;
  logic              accept;

  logic              done_q;
  logic              found_q;
  logic [7:0]        slot_q;
  logic [15:0]       kind_rd_q;
  logic [8:0]        cnt_out_q;
  logic              full_q;

  reply_t            chain [CAPACITY];
  reply_t            grp [NG];
  reply_t            sum;
  cell_wr_t          wr;
  logic [SLOT_W-1:0] slot_n;
  logic              full_n;
  logic [31:0]       cnt_ext;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // item capture, held until the next accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= kind_i;
      key_q   <= {pos_z_i, pos_y_i, pos_x_i};
      bkind_q <= block_kind_i;
    end
  end

  // the cell chain, rippling within groups of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    reply_t link_in;
    if ((i % GROUP) == 0) begin : g_head
      assign link_in = '0;
    end else begin : g_link
      assign link_in = chain[i-1];
    end
    ckbm_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .key_i   (key_q),
      .count_i (count_q),
      .wr_i    (wr),
      .chain_i (link_in),
      .chain_o (chain[i])
    );
  end

  // tap the tail cell of each group
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int unsigned Tail =
      (((g + 1) * GROUP) < CAPACITY) ? ((g + 1) * GROUP - 1) : (CAPACITY - 1);
    assign grp[g] = chain[Tail];
  end

  ckbm_reduce #(
    .NG (NG)
  ) u_reduce (
    .clk_i (clk_i),
    .grp_i (grp),
    .sum_o (sum)
  );

  // operation decode and table update
  always_comb begin
    wr      = '0;
    count_d = count_q;
    slot_n  = sum.hit ? sum.slot : '0;
    full_n  = 1'b0;
    case (op_q)
      OP_SET: begin
        if (sum.hit) begin
          wr = '{we: 1'b1, idx: sum.slot, key: key_q, kind: bkind_q};
        end else if (count_q < CapC) begin
          wr      = '{we: 1'b1, idx: SLOT_W'(count_q), key: key_q, kind: bkind_q};
          slot_n  = SLOT_W'(count_q);
          count_d = count_q + 1'b1;
        end else begin
          full_n = 1'b1;
        end
      end
      OP_DELETE: begin
        if (sum.hit) begin
          wr = '{we: 1'b1, idx: sum.slot, key: sum.last_key, kind: sum.last_kind};
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q != ST_EXEC) begin
      wr.we = 1'b0;
    end
  end

  assign cnt_ext = 32'(count_d);

  // sequencer, entry count and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      done_q    <= 1'b0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      kind_rd_q <= '0;
      cnt_out_q <= '0;
      full_q    <= 1'b0;
    end else begin
      done_q <= (state_q == ST_EXEC);
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP:  state_q <= ST_RED1;
        ST_RED1: state_q <= ST_RED2;
        ST_RED2: state_q <= ST_EXEC;
        ST_EXEC: begin
          state_q   <= ST_IDLE;
          count_q   <= count_d;
          found_q   <= sum.hit;
          slot_q    <= slot_n[7:0];
          kind_rd_q <= sum.kind;
          cnt_out_q <= cnt_ext[8:0];
          full_q    <= full_n;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign slot_o        = slot_q;
  assign kind_read_o   = kind_rd_q;
  assign entry_count_o = cnt_out_q;
  assign table_full_o  = full_q;

`ifndef SYNTH
  // every accepted item is followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("result strobe missing after accepted item");

  // the strobe comes only once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a dropped set never reports a held key
  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (!found_o && (slot_o == 8'd0)))
    else $error("full flag with a found key");

  // the entry count stays within the table
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");
`endif

endmodule

@@ tb/sv/tb_coordinate_keyed_block_map_core.sv @@
// self-checking testbench for the coordinate keyed block map core
module tb_coordinate_keyed_block_map_core;
  import ckbm_pkg::*;

  localparam int unsigned MAP_DEPTH = 256;
  localparam int unsigned POOL_SIZE = 320;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT = 200;
  // op code 3 has no package name; the block treats it as a lookup
  localparam logic [1:0] OP_SPARE = 2'd3;

  // one operation as presented on the input ports
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        bkind;
    bit                 drain;
    bit                 quiet;
  } map_cmd_t;

  // one reply as seen on the result ports
  typedef struct {
    logic       found;
    logic [7:0] slot;
    logic [15:0] kind_read;
    logic [8:0] entry_count;
    logic       table_full;
  } map_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_i = OP_LOOKUP;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic signed [15:0] pos_z_i = '0;
  logic [15:0] block_kind_i = '0;
  logic done_o;
  logic found_o;
  logic [7:0] slot_o;
  logic [15:0] kind_read_o;
  logic [8:0] entry_count_o;
  logic table_full_o;

  coordinate_keyed_block_map_core #(
    .CAPACITY(MAP_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .kind_i(kind_i),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .pos_z_i(pos_z_i),
    .block_kind_i(block_kind_i),
    .done_o(done_o),
    .found_o(found_o),
    .slot_o(slot_o),
    .kind_read_o(kind_read_o),
    .entry_count_o(entry_count_o),
    .table_full_o(table_full_o)
  );

  // shadow copy of the packed table
  logic [47:0] shadow_key [MAP_DEPTH];
  logic [15:0] shadow_kind [MAP_DEPTH];
  int unsigned shadow_count = 0;

  map_cmd_t cmd_queue[$];
  map_reply_t pending_replies[$];
  map_cmd_t cur_cmd;
  map_reply_t mon_want;
  logic [47:0] key_pool [POOL_SIZE];
  int unsigned fresh_cursor = 0;
  int gap_left = 0;
  int fail_count = 0;
  int n_items = 0;
  int n_hits = 0;
  int n_dropped = 0;
  int n_moves = 0;
  int unsigned peak_count = 0;

  // expected reply of one operation, updating the shadow table
  function automatic map_reply_t map_predict(map_cmd_t c);
    map_reply_t r;
    logic [47:0] key;
    int unsigned where;
    int unsigned last;
    bit hit;
    key = {c.z, c.y, c.x};
    hit = 1'b0;
    where = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_key[i] == key) begin
        hit = 1'b1;
        where = i;
      end
    end
    r.found = hit;
    r.kind_read = hit ? shadow_kind[where] : 16'h0000;
    r.table_full = 1'b0;
    case (c.op)
      OP_SET: begin
        if (hit) begin
          shadow_kind[where] = c.bkind;
        end else if (shadow_count < MAP_DEPTH) begin
          shadow_key[shadow_count] = key;
          shadow_kind[shadow_count] = c.bkind;
          where = shadow_count;
          shadow_count++;
        end else begin
          r.table_full = 1'b1;
          n_dropped++;
        end
      end
      OP_DELETE: begin
        // swap the last entry into the freed slot
        if (hit) begin
          last = shadow_count - 1;
          shadow_key[where] = shadow_key[last];
          shadow_kind[where] = shadow_kind[last];
          shadow_count = last;
          n_moves++;
        end
      end
      default: begin
      end
    endcase
    r.slot = (hit || (c.op == OP_SET && !r.table_full)) ? where[7:0] : 8'd0;
    r.entry_count = shadow_count[8:0];
    if (hit) n_hits++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    return r;
  endfunction

  task automatic push_cmd(input logic [1:0] op, input logic [47:0] key,
                          input logic [15:0] bk, input bit drain, input bit quiet);
    map_cmd_t c;
    c.op = op;
    c.x = key[15:0];
    c.y = key[31:16];
    c.z = key[47:32];
    c.bkind = bk;
    c.drain = drain;
    c.quiet = quiet;
    cmd_queue.push_back(c);
  endtask

  // random operations over a slice of the key pool, with fresh set keys and noise keys
  task automatic gen_phase(input int n, input int lo, input int hi, input int w_look,
                           input int w_set, input int w_del, input int fresh_pct,
                           input bit quiet);
    int r;
    logic [1:0] op;
    logic [47:0] key;
    logic [15:0] bk;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < w_look) op = ($urandom_range(9) == 0) ? OP_SPARE : OP_LOOKUP;
      else if (r < w_look + w_set) op = OP_SET;
      else if (r < w_look + w_set + w_del) op = OP_DELETE;
      else op = 2'($urandom_range(3));
      // noise items use keys that are almost never held
      if (r >= w_look + w_set + w_del) begin
        key = 48'({$urandom, $urandom});
      end else if (op == OP_SET && $urandom_range(99) < fresh_pct) begin
        key = key_pool[fresh_cursor % POOL_SIZE];
        fresh_cursor++;
      end else begin
        key = key_pool[$urandom_range(hi, lo)];
      end
      case ($urandom_range(7))
        0: bk = 16'h0000;
        1: bk = 16'hFFFF;
        default: bk = 16'($urandom);
      endcase
      push_cmd(op, key, bk, k == 0, quiet);
    end
  endtask

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // driver: present queued items, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= OP_LOOKUP;
      pos_x_i <= '0;
      pos_y_i <= '0;
      pos_z_i <= '0;
      block_kind_i <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        pending_replies.push_back(map_predict(cur_cmd));
        n_items++;
        if (cmd_queue.size() != 0 && !cmd_queue[0].quiet && $urandom_range(3) == 0) begin
          gap_left = $urandom_range(8, 1);
        end
      end
      // the input side is free once the held item went in
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && pending_replies.size() != 0)) begin
          cur_cmd = cmd_queue.pop_front();
          start <= 1'b1;
          kind_i <= cur_cmd.op;
          pos_x_i <= cur_cmd.x;
          pos_y_i <= cur_cmd.y;
          pos_z_i <= cur_cmd.z;
          block_kind_i <= cur_cmd.bkind;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed reply with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected");
        fail_count++;
      end else begin
        mon_want = pending_replies.pop_front();
        if (found_o !== mon_want.found) begin
          $error("found: expected %0d, actual %0d", mon_want.found, found_o);
          fail_count++;
        end
        if (slot_o !== mon_want.slot) begin
          $error("slot: expected %0d, actual %0d", mon_want.slot, slot_o);
          fail_count++;
        end
        if (kind_read_o !== mon_want.kind_read) begin
          $error("kind_read: expected %0h, actual %0h", mon_want.kind_read, kind_read_o);
          fail_count++;
        end
        if (entry_count_o !== mon_want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", mon_want.entry_count,
                 entry_count_o);
          fail_count++;
        end
        if (table_full_o !== mon_want.table_full) begin
          $error("table_full: expected %0d, actual %0d", mon_want.table_full, table_full_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus, reset and end of run
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 48'({$urandom, $urandom});

    // directed: empty table, coordinate extremes, updates, swap and last deletes
    push_cmd(OP_LOOKUP, {16'h0001, 16'h0002, 16'h0003}, 16'hFFFF, 0, 0);
    push_cmd(OP_DELETE, {16'h0001, 16'h0002, 16'h0003}, 16'h0000, 0, 0);
    push_cmd(OP_SET, {16'h8000, 16'h8000, 16'h8000}, 16'hFFFF, 0, 0);
    push_cmd(OP_SET, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h0000, 0, 0);
    push_cmd(OP_SET, {16'h7FFF, 16'h0000, 16'hFFFF}, 16'h5A5A, 0, 0);
    push_cmd(OP_SET, {16'h8000, 16'h8000, 16'h8000}, 16'h0001, 0, 0);
    push_cmd(OP_LOOKUP, {16'h8000, 16'h8000, 16'h8000}, 16'h1234, 0, 0);
    push_cmd(OP_SPARE, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'hA5A5, 0, 0);
    push_cmd(OP_SPARE, {16'h1111, 16'h2222, 16'h3333}, 16'h0000, 0, 0);
    push_cmd(OP_DELETE, {16'h8000, 16'h8000, 16'h8000}, 16'h0000, 0, 0);
    push_cmd(OP_LOOKUP, {16'h7FFF, 16'h0000, 16'hFFFF}, 16'h0000, 0, 0);
    push_cmd(OP_DELETE, {16'h7FFF, 16'h0000, 16'hFFFF}, 16'h0000, 0, 0);
    push_cmd(OP_DELETE, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h0000, 0, 0);
    push_cmd(OP_LOOKUP, {16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h0000, 0, 0);
    push_cmd(OP_SET, 48'h0, 16'h8000, 0, 0);
    push_cmd(OP_LOOKUP, 48'h0, 16'hFFFF, 0, 0);
    push_cmd(OP_SET, 48'h5555_AAAA_5555, 16'hAAAA, 0, 0);
    push_cmd(OP_SET, 48'hAAAA_5555_AAAA, 16'h5555, 0, 0);
    push_cmd(OP_DELETE, 48'hAAAA_5555_AAAA, 16'hFFFF, 0, 0);
    push_cmd(OP_SPARE, 48'h5555_AAAA_5555, 16'h0000, 0, 0);
    push_cmd(OP_DELETE, 48'h0, 16'h0000, 0, 0);

    // random: churn on few keys, fill past capacity, churn when full, drain
    gen_phase(300, 0, 15, 30, 40, 25, 0, 0);
    gen_phase(450, 0, POOL_SIZE - 1, 10, 85, 0, 80, 0);
    gen_phase(300, 0, POOL_SIZE - 1, 25, 40, 30, 0, 0);
    gen_phase(150, 0, POOL_SIZE - 1, 20, 10, 65, 0, 1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || start) @(posedge clk_i);
    for (int i = 0; i < DRAIN_LIMIT && pending_replies.size() != 0; i++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", pending_replies.size());
      fail_count++;
    end

    $display("ran %0d map operations: %0d key hits, %0d entry moves on delete",
             n_items, n_hits, n_moves);
    $display("occupancy peaked at %0d of %0d slots, %0d sets refused on a full table",
             peak_count, MAP_DEPTH, n_dropped);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
